FILE: hdl/cdq_pkg.sv
package cdq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;

    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int CMD_W     = 3;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_REAR  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_QUERY      = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } t_state;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [WORD_BITS-1:0] t_word;

    // zero acts as one, anything above the ring size is clipped to it
    function automatic t_cnt eff_cap(input logic [CAP_W-1:0] cap);
        t_cnt res;
        if (cap == '0) begin
            res = CNT_W'(1);
        end else if (32'(cap) > DEPTH) begin
            res = CNT_W'(DEPTH);
        end else begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

    function automatic t_idx wrap_next(input t_idx i, input t_cnt cap);
        t_cnt nxt;
        nxt = CNT_W'(i) + CNT_W'(1);
        return (nxt >= cap) ? '0 : IDX_W'(nxt);
    endfunction

    function automatic t_idx wrap_prev(input t_idx i, input t_cnt cap);
        return (i == '0 || CNT_W'(i) >= cap) ? IDX_W'(cap - CNT_W'(1))
                                             : IDX_W'(i - IDX_W'(1));
    endfunction

    function automatic logic [DATA_W-1:0] sext_word(input t_word w);
        return DATA_W'(signed'(w));
    endfunction

endpackage

FILE: hdl/circular_deque.sv
// Double-ended queue of signed words in a ring of up to 16 entries. A command
// is taken when start is high and busy is low; busy then stays high through
// the READ and RESP states, and the result appears on the o_ ports, marked by
// o_done, for one cycle, in RESP. A new command can be taken only once busy
// is low again, so commands do not overlap. The states step through the ring
// memory in order: the pointers are updated and a pushed word written as the
// command is taken, READ does the registered read of the new front and rear
// entries, and RESP presents the result on the o_ ports.
// The receiver cannot stall a result. Writing the capacity register
// (byte address 0) empties the queue; write it only while busy is low.
module circular_deque (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cdq_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_value,
    output logic                              o_done,
    output logic                              o_accepted,
    output logic signed [cdq_pkg::DATA_W-1:0] o_front_word,
    output logic signed [cdq_pkg::DATA_W-1:0] o_rear_word,
    output logic [cdq_pkg::CAP_W-1:0]         o_count,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cdq_pkg::PADDR_W-1:0]       paddr,
    input  logic [cdq_pkg::DATA_W-1:0]        pwdata,
    output logic [cdq_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import cdq_pkg::*;

    t_state             r_state, n_state;
    t_idx               r_head, n_head;
    t_idx               r_tail, n_tail;
    t_cnt               r_occ, n_occ;
    logic               r_ok, n_ok;
    logic [CAP_W-1:0]   r_cap;
    t_word              r_rd_front, r_rd_rear;

    t_word              ring_mem [DEPTH];
    logic               wr_en;
    t_idx               wr_addr;

    t_cnt               cap_now;
    logic               full, empty;
    logic               cfg_wr;

    assign cap_now = eff_cap(r_cap);
    assign full    = r_occ >= cap_now;
    assign empty   = r_occ == '0;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == 1'b0);

    assign pready  = 1'b1;
    assign prdata  = (paddr[PADDR_W-1] == 1'b0) ? DATA_W'(r_cap) : '0;
    assign busy    = r_state != ST_IDLE;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_occ   = r_occ;
        n_ok    = r_ok;
        wr_en   = 1'b0;
        wr_addr = r_tail;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_READ;
                    n_ok    = 1'b1;
                    unique case (t_cmd'(i_cmd))
                        CMD_PUSH_REAR: begin
                            if (full) begin
                                n_ok = 1'b0;
                            end else begin
                                n_tail  = wrap_next(r_tail, cap_now);
                                wr_en   = 1'b1;
                                wr_addr = n_tail;
                                n_occ   = r_occ + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_ok = 1'b0;
                            end else begin
                                n_head  = wrap_prev(r_head, cap_now);
                                wr_en   = 1'b1;
                                wr_addr = n_head;
                                n_occ   = r_occ + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                n_ok = 1'b0;
                            end else begin
                                n_head = wrap_next(r_head, cap_now);
                                n_occ  = r_occ - CNT_W'(1);
                            end
                        end
                        CMD_POP_REAR: begin
                            if (empty) begin
                                n_ok = 1'b0;
                            end else begin
                                n_tail = wrap_prev(r_tail, cap_now);
                                n_occ  = r_occ - CNT_W'(1);
                            end
                        end
                        CMD_QUERY: begin
                            n_ok = 1'b1;
                        end
                        default: begin
                            // unknown codes report like a query but rejected
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: n_state = ST_RESP;
            ST_RESP: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        // capacity write empties the queue
        if (cfg_wr) begin
            n_head = '0;
            n_tail = IDX_W'(eff_cap(pwdata[CAP_W-1:0]) - CNT_W'(1));
            n_occ  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= IDX_W'(eff_cap(CAP_RESET) - CNT_W'(1));
            r_occ   <= '0;
            r_ok    <= 1'b0;
            r_cap   <= CAP_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_ok    <= n_ok;
            if (cfg_wr) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= WORD_BITS'($unsigned(i_value));
        end
    end

    // pointers already hold the post-command values here
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd_front <= ring_mem[r_head];
            r_rd_rear  <= ring_mem[r_tail];
        end
    end

    assign o_done       = r_state == ST_RESP;
    assign o_accepted   = r_ok;
    assign o_is_empty   = empty;
    assign o_is_full    = full;
    assign o_count      = CAP_W'(r_occ);
    assign o_front_word = empty ? '1 : signed'(sext_word(r_rd_front));
    assign o_rear_word  = empty ? '1 : signed'(sext_word(r_rd_rear));

endmodule

FILE: hdl/cdq_checker.sv
module cdq_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              o_done,
    input  logic signed [cdq_pkg::DATA_W-1:0] o_front_word,
    input  logic signed [cdq_pkg::DATA_W-1:0] o_rear_word,
    input  logic [cdq_pkg::CAP_W-1:0]         o_count,
    input  logic                              o_is_empty,
    input  logic                              o_is_full
);
    import cdq_pkg::*;

    // every accepted request gets its result once the deque has passed through READ into RESP
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result missing after accepted request");

    // a result only shows while its request is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (busy && $past(busy)))
        else $error("result without request in flight");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result repeated");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_empty) |->
            (o_count == '0 && o_front_word == -32'sd1 && o_rear_word == -32'sd1
             && !o_is_full))
        else $error("empty result inconsistent");

    a_count_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_count == '0) |-> o_is_empty)
        else $error("zero count without empty flag");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
